@@ rtl/core/stlru_pkg.sv @@
`timescale 1ns / 1ps

package stlru_pkg;

	localparam int SLOTS = 32;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SLOT_INDEX_W = 5;

	typedef enum logic [1:0] {
		ACT_LOGIN  = 2'd0,
		ACT_CHECK  = 2'd1,
		ACT_LOGOUT = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [63:0] session_high;
		logic [63:0] session_low;
		logic [31:0] address;
		logic [31:0] last_active;
	} entry_t;

endpackage

@@ rtl/core/stlru_mem.sv @@
`timescale 1ns / 1ps

module stlru_mem
	import stlru_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/session_table_lru.sv @@
`timescale 1ns / 1ps

// Session table with least recently used replacement.
// Input channel: action, session_high, session_low, client_address and
// now_seconds, transferred when in_valid is high and in_stall is low.
// Output channel: status, slot_index and evicted, transferred when out_valid
// is high and out_stall is low. Every input transfer yields one result.
// Entries live in a single-port-read, single-port-write memory with a
// registered read port; valid bits are flip-flops. Each request scans all
// SLOTS entries, one read per cycle, tracking the first empty slot, the
// oldest slot and the first match, then writes back at most once.
// One request is in flight at a time; a new one is taken only after the
// previous request has scanned all slots and written back.
// in_stall is high while a request is in flight. A new request may be taken
// while the previous result waits in the output register; its write-back
// holds until that result transfers.
// Reset clears all valid bits (empty table) and the control state at once;
// no clearing pass is needed.
module session_table_lru_core
	import stlru_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              action,
	input  logic [63:0]             session_high,
	input  logic [63:0]             session_low,
	input  logic [31:0]             client_address,
	input  logic [31:0]             now_seconds,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    status,
	output logic [SLOT_INDEX_W-1:0] slot_index,
	output logic                    evicted
);

	state_t state_q, state_d;

	logic [1:0]       action_q;
	logic [63:0]      hi_q;
	logic [63:0]      lo_q;
	logic [31:0]      addr_q;
	logic [31:0]      now_q;

	logic [SLOTS-1:0] valid_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             found_q;
	logic [IDX_W-1:0] tgt_q;
	logic [31:0]      min_q;
	logic [IDX_W-1:0] min_idx_q;

	logic                    out_valid_q;
	logic                    status_q;
	logic [SLOT_INDEX_W-1:0] slot_index_q;
	logic                    evicted_q;

	entry_t           rdata;
	entry_t           wdata;
	logic             mem_we;
	logic [IDX_W-1:0] write_idx;

	logic accept;
	logic issue;
	logic last_eval;
	logic can_go;
	logic id_hit;
	logic hit;
	logic empty_hit;
	logic older;

	stlru_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (write_idx),
		.wdata (wdata),
		.raddr (rd_ptr_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign accept    = in_valid && !in_stall;
	assign issue     = (state_q == ST_SCAN) && (rd_ptr_q < CNT_W'(SLOTS));
	assign last_eval = vld_s1 && (idx_s1 == IDX_W'(SLOTS - 1));
	assign can_go    = !out_valid_q || !out_stall;

	assign id_hit    = valid_q[idx_s1] && (rdata.session_high == hi_q) &&
	                   (rdata.session_low == lo_q);
	assign empty_hit = !valid_q[idx_s1];
	assign older     = (idx_s1 == '0) || (rdata.last_active < min_q);

	always_comb begin
		hit = 1'b0;
		case (action_q)
			ACT_LOGIN:  hit = empty_hit;
			ACT_CHECK:  hit = id_hit && (rdata.address == addr_q);
			ACT_LOGOUT: hit = id_hit;
			default:    hit = 1'b0;
		endcase
	end

	assign write_idx = found_q ? tgt_q : min_idx_q;
	assign wdata     = '{session_high: hi_q, session_low: lo_q,
	                     address: addr_q, last_active: now_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mem_we   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_eval) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (can_go) begin
					state_d = ST_IDLE;
					mem_we  = (action_q == ACT_LOGIN) ||
					          ((action_q == ACT_CHECK) && found_q);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			hi_q     <= session_high;
			lo_q     <= session_low;
			addr_q   <= client_address;
			now_q    <= now_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (accept) begin
				rd_ptr_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + CNT_W'(1);
				end
				if (vld_s1 && !found_q && hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_ptr_q[IDX_W-1:0];
		end
		if (vld_s1 && !found_q && hit) begin
			tgt_q <= idx_s1;
		end
		if (vld_s1 && older) begin
			min_q     <= rdata.last_active;
			min_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if ((state_q == ST_WRITE) && can_go) begin
			if (action_q == ACT_LOGIN) begin
				valid_q[write_idx] <= 1'b1;
			end else if ((action_q == ACT_LOGOUT) && found_q) begin
				valid_q[tgt_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_WRITE) && can_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WRITE) && can_go) begin
			case (action_q) inside
				ACT_LOGIN: begin
					status_q     <= 1'b0;
					slot_index_q <= SLOT_INDEX_W'(write_idx);
					evicted_q    <= !found_q;
				end
				ACT_CHECK, ACT_LOGOUT: begin
					status_q     <= !found_q;
					slot_index_q <= found_q ? SLOT_INDEX_W'(tgt_q) : '0;
					evicted_q    <= 1'b0;
				end
				default: begin
					status_q     <= 1'b1;
					slot_index_q <= '0;
					evicted_q    <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_index_q;
	assign evicted    = evicted_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import stlru_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic                    status;
		logic [SLOT_INDEX_W-1:0] slot;
		logic                    evicted;
	} session_reply_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [1:0]              action = '0;
	logic [63:0]             session_high = '0;
	logic [63:0]             session_low = '0;
	logic [31:0]             client_address = '0;
	logic [31:0]             now_seconds = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    status;
	logic [SLOT_INDEX_W-1:0] slot_index;
	logic                    evicted;

	logic        sess_valid [SLOTS];
	logic [63:0] sess_high [SLOTS];
	logic [63:0] sess_low [SLOTS];
	logic [31:0] sess_addr [SLOTS];
	logic [31:0] sess_last [SLOTS];

	session_reply_t expected_replies [$];
	session_reply_t want;
	bit             steady_traffic = 1'b0;
	logic [31:0]    clock_now = 32'd1000;
	int             requests_sent = 0;
	int             replies_checked = 0;
	int             evictions_seen = 0;
	int             misses_seen = 0;
	int             mismatch_count = 0;

	session_table_lru_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.session_high   (session_high),
		.session_low    (session_low),
		.client_address (client_address),
		.now_seconds    (now_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.slot_index     (slot_index),
		.evicted        (evicted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= !steady_traffic && ($urandom_range(0, 99) < 27);
	end

	function automatic session_reply_t apply_session_request(logic [1:0] act,
			logic [63:0] hi, logic [63:0] lo, logic [31:0] addr, logic [31:0] now);
		session_reply_t r;
		int target;
		int i;
		r = '{status: 1'b1, slot: '0, evicted: 1'b0};
		case (act)
			ACT_LOGIN: begin
				target = -1;
				for (i = 0; i < SLOTS; i++)
					if (!sess_valid[i] && target < 0)
						target = i;
				if (target < 0) begin
					target = 0;
					for (i = 1; i < SLOTS; i++)
						if (sess_last[i] < sess_last[target])
							target = i;
					r.evicted = 1'b1;
				end
				sess_valid[target] = 1'b1;
				sess_high[target] = hi;
				sess_low[target] = lo;
				sess_addr[target] = addr;
				sess_last[target] = now;
				r.status = 1'b0;
				r.slot = SLOT_INDEX_W'(target);
			end
			ACT_CHECK: begin
				for (i = SLOTS - 1; i >= 0; i--)
					if (sess_valid[i] && sess_high[i] == hi && sess_low[i] == lo
							&& sess_addr[i] == addr)
						target = i;
				if (r.status == 1'b1 && target >= 0 && target < SLOTS
						&& sess_valid[target] && sess_high[target] == hi
						&& sess_low[target] == lo && sess_addr[target] == addr) begin
					sess_last[target] = now;
					r.status = 1'b0;
					r.slot = SLOT_INDEX_W'(target);
				end
			end
			ACT_LOGOUT: begin
				target = -1;
				for (i = SLOTS - 1; i >= 0; i--)
					if (sess_valid[i] && sess_high[i] == hi && sess_low[i] == lo)
						target = i;
				if (target >= 0) begin
					sess_valid[target] = 1'b0;
					r.status = 1'b0;
					r.slot = SLOT_INDEX_W'(target);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_live_slot();
		int start;
		int i;
		int k;
		start = $urandom_range(0, SLOTS - 1);
		for (i = 0; i < SLOTS; i++) begin
			k = (start + i) % SLOTS;
			if (sess_valid[k])
				return k;
		end
		return -1;
	endfunction

	task automatic issue_request(logic [1:0] act, logic [63:0] hi, logic [63:0] lo,
			logic [31:0] addr, logic [31:0] now);
		if (!steady_traffic && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		session_high <= hi;
		session_low <= lo;
		client_address <= addr;
		now_seconds <= now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_replies.push_back(apply_session_request(act, hi, lo, addr, now));
		requests_sent++;
	endtask

	task automatic wait_for_replies();
		in_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			replies_checked++;
			evictions_seen += evicted;
			misses_seen += status;
			if (expected_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with nothing pending: status %0d slot %0d evicted %0d",
						$time, status, slot_index, evicted);
			end else begin
				want = expected_replies.pop_front();
				if (status !== want.status || slot_index !== want.slot
						|| evicted !== want.evicted) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch: expected status %0d slot %0d evicted %0d, got %0d %0d %0d",
							$time, want.status, want.slot, want.evicted,
							status, slot_index, evicted);
				end
			end
		end
	end

	task automatic test_directed();
		logic [63:0] ones;
		logic [63:0] id_a_hi;
		logic [63:0] id_a_lo;
		ones = '1;
		id_a_hi = 64'h0123_4567_89ab_cdef;
		id_a_lo = 64'hfedc_ba98_7654_3210;
		issue_request(ACT_CHECK, '0, '0, '0, 32'd1);
		issue_request(ACT_LOGOUT, '0, '0, '0, 32'd1);
		issue_request(ACT_LOGIN, '0, '0, '0, '0);
		issue_request(ACT_LOGIN, ones, ones, '1, '1);
		issue_request(ACT_CHECK, '0, '0, '0, 32'd5);
		issue_request(ACT_CHECK, ones, ones, '1, '1);
		issue_request(ACT_CHECK, ones, ones, 32'hffff_fffe, 32'd6);
		issue_request(ACT_CHECK, ones, '0, '1, 32'd6);
		issue_request(ACT_UNUSED, ones, ones, '1, 32'd7);
		issue_request(ACT_LOGIN, id_a_hi, id_a_lo, 32'h0a00_0001, 32'd8);
		issue_request(ACT_LOGIN, id_a_hi, id_a_lo, 32'h0a00_0002, 32'd9);
		issue_request(ACT_CHECK, id_a_hi, id_a_lo, 32'h0a00_0002, 32'd10);
		issue_request(ACT_LOGOUT, id_a_hi, id_a_lo, 32'hc0a8_0101, 32'd11);
		issue_request(ACT_CHECK, id_a_hi, id_a_lo, 32'h0a00_0001, 32'd12);
		issue_request(ACT_CHECK, id_a_hi, id_a_lo, 32'h0a00_0002, 32'd13);
		issue_request(ACT_LOGIN, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
			32'h5a5a_a5a5, 32'd14);
		issue_request(ACT_LOGOUT, ones, ones, '0, 32'd15);
		issue_request(ACT_LOGOUT, ones, ones, '1, 32'd16);
		issue_request(ACT_LOGOUT, '0, '0, '1, 32'd17);
		issue_request(ACT_CHECK, '0, '0, '0, 32'd18);
	endtask

	// fill the table with close stamps, then force replacements with ties
	task automatic test_lru_eviction();
		repeat (SLOTS + 16)
			issue_request(ACT_LOGIN, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
				32'd100 + $urandom_range(0, 3));
	endtask

	task automatic test_random_traffic(int count);
		int          pick;
		int          slot;
		logic [1:0]  act;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [31:0] addr;
		logic [31:0] now;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			slot = pick_live_slot();
			hi = {$urandom, $urandom};
			lo = {$urandom, $urandom};
			addr = $urandom;
			clock_now = clock_now + $urandom_range(0, 3);
			now = ($urandom_range(0, 99) < 5) ? $urandom : clock_now;
			if (pick < 45) begin
				act = ACT_LOGIN;
			end else if (pick < 50) begin
				act = ACT_LOGIN;
				if (slot >= 0) begin
					hi = sess_high[slot];
					lo = sess_low[slot];
				end
			end else if (pick < 80) begin
				act = ACT_CHECK;
				if (slot >= 0) begin
					hi = sess_high[slot];
					lo = sess_low[slot];
					if (pick < 75)
						addr = sess_addr[slot];
				end
			end else if (pick < 83) begin
				act = ACT_CHECK;
			end else if (pick < 97) begin
				act = ACT_LOGOUT;
				if (slot >= 0 && pick < 93) begin
					hi = sess_high[slot];
					lo = sess_low[slot];
				end
			end else begin
				act = ACT_UNUSED;
			end
			issue_request(act, hi, lo, addr, now);
		end
	endtask

	initial begin
		foreach (sess_valid[i])
			sess_valid[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_lru_eviction();
		test_random_traffic(150);
		wait_for_replies();
		steady_traffic = 1'b1;
		test_random_traffic(100);
		steady_traffic = 1'b0;
		test_random_traffic(150);
		wait_for_replies();
		repeat (40) @(posedge clk);
		$display("summary: %0d requests sent, %0d results checked, %0d mismatches",
			requests_sent, replies_checked, mismatch_count);
		$display("summary: %0d replacements of occupied slots, %0d lookups without a match",
			evictions_seen, misses_seen);
		if (mismatch_count == 0 && expected_replies.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
